@@ hdl/bfr_pkg.sv @@
// package for the byte frequency rank block
// holds request codes, field widths and parameter defaults; no dependencies
package bfr_pkg;

   localparam int SYMBOL_COUNT_DEF = 256;
   localparam int COUNT_BITS_DEF   = 32;

   localparam int BYTE_W  = 8;
   localparam int FREQ_W  = 32;
   localparam int REQ_W   = 2;
   localparam int DIST_W  = 9;

   typedef logic [REQ_W-1:0] req_code_type;

   localparam req_code_type REQ_CLEAR = 2'd0;
   localparam req_code_type REQ_COUNT = 2'd1;
   localparam req_code_type REQ_QUERY = 2'd2;

endpackage

@@ hdl/bfr_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module bfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bfr_cmp.sv @@
// ordering compare: does symbol t rank ahead of the symbol under test
// descending count, ties by earlier arrival; uses bfr_pkg
module bfr_cmp #(
   parameter int COUNT_BITS = bfr_pkg::COUNT_BITS_DEF
) (
   input  logic                          t_live,
   input  logic [COUNT_BITS-1:0]         t_count,
   input  logic [bfr_pkg::BYTE_W-1:0]    t_arrival,
   input  logic [COUNT_BITS-1:0]         s_count,
   input  logic [bfr_pkg::BYTE_W-1:0]    s_arrival,
   output logic                          ahead
);
   import bfr_pkg::*;

   logic cnt_gt;
   logic cnt_eq;
   logic arr_lt;

   always_comb begin
      cnt_gt = t_count > s_count;
      cnt_eq = t_count == s_count;
      arr_lt = t_arrival < s_arrival;
      ahead  = t_live && (cnt_gt || (cnt_eq && arr_lt));
   end

endmodule

@@ hdl/byte_frequency_rank.sv @@
// byte frequency rank: histogram of byte values with rank queries
// uses bfr_pkg, bfr_ram (count and arrival stores) and bfr_cmp
//
//   channel | ports                                  | direction
//   req     | req_valid req_ready req_type           | in
//           | req_byte_value req_rank_index          |
//   rsp     | rsp_valid rsp_ready rsp_symbol         | out
//           | rsp_frequency rsp_found                |
//
// clear item: drops all entry valid bits at once
// count item: read then write back of one count ram entry
// query item: goes straight to the result when the rank is not found;
//   otherwise each candidate symbol is checked by scanning the count ram
//   through its one read port
// new items are taken while a result waits in the output, not in ST_RESP
// synchronous active high reset clears control state and the entry valid bits
module byte_frequency_rank #(
   parameter int SYMBOL_COUNT = bfr_pkg::SYMBOL_COUNT_DEF,
   parameter int COUNT_BITS   = bfr_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [bfr_pkg::REQ_W-1:0]   req_type,
   input  logic [bfr_pkg::BYTE_W-1:0]  req_byte_value,
   input  logic [bfr_pkg::BYTE_W-1:0]  req_rank_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bfr_pkg::BYTE_W-1:0]  rsp_symbol,
   output logic [bfr_pkg::FREQ_W-1:0]  rsp_frequency,
   output logic                        rsp_found
);
   import bfr_pkg::*;

   localparam int SYM_BITS = $clog2(SYMBOL_COUNT);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CNT  = 3'd1;
   localparam logic [2:0] ST_SSEL = 3'd2;
   localparam logic [2:0] ST_SLD  = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_RESP = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [SYMBOL_COUNT-1:0] live_ff, live_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic [SYM_BITS-1:0] addr_ff, addr_in;
   logic [SYM_BITS-1:0] s_ff, s_in;
   logic [SYM_BITS:0] t_ff, t_in;
   logic [SYM_BITS-1:0] td_ff, td_in;
   logic pv_ff, pv_in;
   logic [DIST_W-1:0] ahead_ff, ahead_in;
   logic [BYTE_W-1:0] rank_ff, rank_in;
   logic [COUNT_BITS-1:0] cs_ff, cs_in;
   logic [BYTE_W-1:0] as_ff, as_in;
   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic [FREQ_W-1:0] rsp_freq_ff, rsp_freq_in;
   logic rsp_found_ff, rsp_found_in;

   logic req_fire;
   logic [SYM_BITS-1:0] rd_addr;
   logic [COUNT_BITS-1:0] cnt_rd;
   logic [BYTE_W-1:0] arr_rd;
   logic cnt_we, arr_we;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic cur_live;
   logic t_live;
   logic is_ahead;
   logic [DIST_W-1:0] ahead_sum;
   logic byte_in_range;
   logic [63:0] cs_wide;

   assign req_ready = state_ff == ST_IDLE;
   assign req_fire  = req_valid && req_ready;
   assign byte_in_range = {1'b0, req_byte_value} < (BYTE_W+1)'(SYMBOL_COUNT);
   assign cur_live = live_ff[addr_ff];
   assign t_live   = live_ff[td_ff] && (td_ff != s_ff);
   assign ahead_sum = ahead_ff + DIST_W'(is_ahead);
   assign cs_wide = 64'(cs_ff);

   bfr_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOL_COUNT)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (addr_ff),
      .wr_data (cnt_wdata),
      .rd_addr (rd_addr),
      .rd_data (cnt_rd)
   );

   bfr_ram #(.WIDTH(BYTE_W), .DEPTH(SYMBOL_COUNT)) u_arr_ram (
      .clock   (clock),
      .wr_en   (arr_we),
      .wr_addr (addr_ff),
      .wr_data (dist_ff[BYTE_W-1:0]),
      .rd_addr (rd_addr),
      .rd_data (arr_rd)
   );

   bfr_cmp #(.COUNT_BITS(COUNT_BITS)) u_cmp (
      .t_live    (t_live),
      .t_count   (cnt_rd),
      .t_arrival (arr_rd),
      .s_count   (cs_ff),
      .s_arrival (as_ff),
      .ahead     (is_ahead)
   );

   always_comb begin
      state_in     = state_ff;
      live_in      = live_ff;
      dist_in      = dist_ff;
      addr_in      = addr_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      td_in        = td_ff;
      pv_in        = 1'b0;
      ahead_in     = ahead_ff;
      rank_in      = rank_ff;
      cs_in        = cs_ff;
      as_in        = as_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_freq_in  = rsp_freq_ff;
      rsp_found_in = rsp_found_ff;
      rd_addr      = req_byte_value[SYM_BITS-1:0];
      cnt_we       = 1'b0;
      arr_we       = 1'b0;
      cnt_wdata    = cnt_rd;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_type)
                  REQ_CLEAR: begin
                     live_in = '0;
                     dist_in = '0;
                  end
                  REQ_COUNT: begin
                     if (byte_in_range) begin
                        addr_in  = req_byte_value[SYM_BITS-1:0];
                        state_in = ST_CNT;
                     end
                  end
                  REQ_QUERY: begin
                     rank_in = req_rank_index;
                     s_in    = '0;
                     if ({1'b0, req_rank_index} < dist_ff) begin
                        state_in = ST_SSEL;
                     end else begin
                        s_in     = '0;
                        cs_in    = '0;
                        found_in = 1'b0;
                        state_in = ST_RESP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CNT: begin
            cnt_we = 1'b1;
            if (!cur_live) begin
               cnt_wdata        = COUNT_BITS'(1);
               arr_we           = 1'b1;
               live_in[addr_ff] = 1'b1;
               dist_in          = dist_ff + DIST_W'(1);
            end else if (!(&cnt_rd)) begin
               cnt_wdata = cnt_rd + COUNT_BITS'(1);
            end
            state_in = ST_IDLE;
         end
         ST_SSEL: begin
            rd_addr = s_ff;
            if (live_ff[s_ff]) begin
               state_in = ST_SLD;
            end else begin
               s_in = s_ff + SYM_BITS'(1);
            end
         end
         ST_SLD: begin
            cs_in    = cnt_rd;
            as_in    = arr_rd;
            t_in     = '0;
            ahead_in = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // stream reads of t, compare in the cycle after each read
            rd_addr = t_ff[SYM_BITS-1:0];
            if (t_ff < (SYM_BITS+1)'(SYMBOL_COUNT)) begin
               pv_in = 1'b1;
               td_in = t_ff[SYM_BITS-1:0];
               t_in  = t_ff + (SYM_BITS+1)'(1);
            end
            if (pv_ff) begin
               ahead_in = ahead_sum;
               if (td_ff == SYM_BITS'(SYMBOL_COUNT - 1)) begin
                  pv_in = 1'b0;
                  if (ahead_sum == {1'b0, rank_ff}) begin
                     found_in = 1'b1;
                     state_in = ST_RESP;
                  end else begin
                     s_in     = s_ff + SYM_BITS'(1);
                     state_in = ST_SSEL;
                  end
               end
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_symbol_in = BYTE_W'(s_ff);
               rsp_freq_in   = cs_wide[FREQ_W-1:0];
               rsp_found_in  = found_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         dist_ff      <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         dist_ff      <= dist_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff       <= addr_in;
      s_ff          <= s_in;
      t_ff          <= t_in;
      td_ff         <= td_in;
      ahead_ff      <= ahead_in;
      rank_ff       <= rank_in;
      cs_ff         <= cs_in;
      as_ff         <= as_in;
      found_ff      <= found_in;
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_freq_ff   <= rsp_freq_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_symbol    = rsp_symbol_ff;
   assign rsp_frequency = rsp_freq_ff;
   assign rsp_found     = rsp_found_ff;

endmodule

@@ sim/byte_frequency_rank_tb.sv @@
// testbench for byte_frequency_rank: directed table, full alphabet run, then random count/query runs
// checks each rank answer against a local histogram or a typed answer; depends on bfr_pkg and the block
module byte_frequency_rank_tb;
   import bfr_pkg::*;

   typedef struct {
      logic [BYTE_W-1:0] symbol;
      logic [FREQ_W-1:0] frequency;
      logic              found;
   } rank_answer_type;

   typedef struct {
      req_code_type      code;
      logic [BYTE_W-1:0] byte_value;
      logic [BYTE_W-1:0] rank_index;
      bit                typed;
      rank_answer_type   answer;
   } stim_row_type;

   localparam req_code_type REQ_UNUSED = 2'd3;
   localparam int QUIET_AFTER = 260;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_code_type req_type = REQ_CLEAR;
   logic [BYTE_W-1:0] req_byte_value = '0;
   logic [BYTE_W-1:0] req_rank_index = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_symbol;
   logic [FREQ_W-1:0] rsp_frequency;
   logic rsp_found;

   // local copy of the histogram
   logic [FREQ_W-1:0] freq_table [SYMBOL_COUNT_DEF];
   logic [7:0]        arrival_rank [SYMBOL_COUNT_DEF];
   logic [DIST_W-1:0] distinct_seen;

   rank_answer_type expected_answers[$];
   int errors = 0;
   int items_taken = 0;
   bit quiet = 1'b0;
   bit cur_typed = 1'b0;
   rank_answer_type cur_answer;

   byte_frequency_rank i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_byte_value(req_byte_value), .req_rank_index(req_rank_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_symbol(rsp_symbol),
      .rsp_frequency(rsp_frequency), .rsp_found(rsp_found)
   );

   always #10 clock = ~clock;

   initial begin
      #400_000_000;
      $display("tb: failure");
      $finish;
   end

   function automatic void clear_histogram();
      for (int s = 0; s < SYMBOL_COUNT_DEF; s++) begin
         freq_table[s] = '0;
         arrival_rank[s] = '0;
      end
      distinct_seen = '0;
   endfunction

   function automatic void tally_byte(logic [BYTE_W-1:0] b);
      if (freq_table[b] == '0) begin
         arrival_rank[b] = distinct_seen[7:0];
         distinct_seen = distinct_seen + 1'b1;
      end
      if (freq_table[b] != '1)
         freq_table[b] = freq_table[b] + 1'b1;
   endfunction

   function automatic rank_answer_type answer_rank(logic [BYTE_W-1:0] rank);
      rank_answer_type a;
      int ahead;
      a.symbol = '0;
      a.frequency = '0;
      a.found = 1'b0;
      if (rank < distinct_seen) begin
         for (int s = 0; s < SYMBOL_COUNT_DEF; s++) begin
            if (freq_table[s] == '0) continue;
            ahead = 0;
            for (int t = 0; t < SYMBOL_COUNT_DEF; t++) begin
               if (t == s || freq_table[t] == '0) continue;
               if (freq_table[t] > freq_table[s] ||
                   (freq_table[t] == freq_table[s] && arrival_rank[t] < arrival_rank[s]))
                  ahead++;
            end
            if (ahead == rank) begin
               a.symbol = s[7:0];
               a.frequency = freq_table[s];
               a.found = 1'b1;
               return a;
            end
         end
      end
      return a;
   endfunction

   // accepted items update the histogram; answers are checked in order
   always @(posedge clock) begin
      rank_answer_type want;
      if (!reset && req_valid && req_ready) begin
         items_taken++;
         case (req_type)
            REQ_CLEAR: clear_histogram();
            REQ_COUNT: tally_byte(req_byte_value);
            REQ_QUERY: begin
               want = answer_rank(req_rank_index);
               expected_answers.push_back(cur_typed ? cur_answer : want);
            end
            default: ;
         endcase
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected answer: symbol %0d", rsp_symbol);
            errors++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_symbol !== want.symbol) begin
               $error("symbol: expected %0d, got %0d", want.symbol, rsp_symbol);
               errors++;
            end
            if (rsp_frequency !== want.frequency) begin
               $error("frequency: expected %0d, got %0d", want.frequency, rsp_frequency);
               errors++;
            end
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               errors++;
            end
         end
      end
   end

   // response side back-pressure in bursts
   always @(negedge clock) begin
      int stall;
      if (reset || quiet) begin
         rsp_ready <= !reset;
         stall = 0;
      end else if (stall > 0) begin
         rsp_ready <= 1'b0;
         stall--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(req_code_type code, logic [BYTE_W-1:0] b,
                            logic [BYTE_W-1:0] r, bit typed, rank_answer_type ans);
      int taken;
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      taken = items_taken;
      req_valid <= 1'b1;
      req_type <= code;
      req_byte_value <= b;
      req_rank_index <= r;
      cur_typed = typed;
      cur_answer = ans;
      do @(negedge clock); while (items_taken == taken);
   endtask

   task automatic send_plain(req_code_type code, logic [BYTE_W-1:0] b,
                             logic [BYTE_W-1:0] r);
      rank_answer_type none;
      none = '{symbol: '0, frequency: '0, found: 1'b0};
      send_item(code, b, r, 1'b0, none);
   endtask

   localparam rank_answer_type MISS = '{symbol: 8'd0, frequency: 32'd0, found: 1'b0};

   stim_row_type directed [] = '{
      '{REQ_QUERY, 8'h00, 8'd0,   1'b1, MISS},                   // empty after reset
      '{REQ_UNUSED, 8'hAA, 8'h55, 1'b0, MISS},                   // unused code ignored
      '{REQ_COUNT, 8'h00, 8'h00,  1'b0, MISS},
      '{REQ_COUNT, 8'hFF, 8'hFF,  1'b0, MISS},
      '{REQ_COUNT, 8'h00, 8'h00,  1'b0, MISS},
      '{REQ_COUNT, 8'h00, 8'h00,  1'b0, MISS},
      '{REQ_QUERY, 8'h00, 8'd0,   1'b1, '{8'h00, 32'd3, 1'b1}},
      '{REQ_QUERY, 8'hFF, 8'd1,   1'b1, '{8'hFF, 32'd1, 1'b1}},
      '{REQ_QUERY, 8'h00, 8'd2,   1'b1, MISS},                   // just past the end
      '{REQ_QUERY, 8'h00, 8'd255, 1'b1, MISS},
      '{REQ_CLEAR, 8'hFF, 8'hFF,  1'b0, MISS},
      '{REQ_QUERY, 8'h00, 8'd0,   1'b1, MISS},
      // ties keep first-appearance order
      '{REQ_COUNT, 8'h05, 8'h00,  1'b0, MISS},
      '{REQ_COUNT, 8'h07, 8'h00,  1'b0, MISS},
      '{REQ_COUNT, 8'h03, 8'h00,  1'b0, MISS},
      '{REQ_COUNT, 8'h07, 8'h00,  1'b0, MISS},
      '{REQ_COUNT, 8'h05, 8'h00,  1'b0, MISS},
      '{REQ_QUERY, 8'h00, 8'd0,   1'b0, MISS},
      '{REQ_QUERY, 8'h00, 8'd1,   1'b0, MISS},
      '{REQ_QUERY, 8'h00, 8'd2,   1'b0, MISS},
      '{REQ_UNUSED, 8'h00, 8'd0,  1'b0, MISS},
      '{REQ_QUERY, 8'h00, 8'd3,   1'b0, MISS}
   };

   initial begin
      int sent;
      int n;
      int perm [256];
      int j;
      int tmp;
      clear_histogram();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_item(directed[i].code, directed[i].byte_value, directed[i].rank_index,
                   directed[i].typed, directed[i].answer);

      // full alphabet once, so the highest rank is found
      send_plain(REQ_CLEAR, '0, '0);
      for (int i = 0; i < 256; i++) perm[i] = i;
      for (int i = 255; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
      end
      for (int i = 0; i < 256; i++) send_plain(REQ_COUNT, perm[i][7:0], '0);
      send_plain(REQ_COUNT, perm[200][7:0], '0);
      send_plain(REQ_QUERY, '0, 8'd255);
      send_plain(REQ_QUERY, '0, 8'd0);
      send_plain(REQ_CLEAR, '0, '0);

      // random runs: clear, a small histogram, interleaved rank queries
      sent = 0;
      while (sent < 320) begin
         if (sent > QUIET_AFTER) quiet = 1'b1;
         if ($urandom_range(0, 3) != 0) begin
            send_plain(REQ_CLEAR, 8'($urandom), 8'($urandom));
            sent++;
         end
         n = $urandom_range(1, 14);
         for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: send_plain(REQ_COUNT,
                  8'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(248, 255)),
                  8'($urandom));
               5: send_plain(REQ_COUNT, 8'($urandom), 8'($urandom));
               6, 7: send_plain(REQ_QUERY, 8'($urandom), 8'($urandom_range(0, 10)));
               8: send_plain(REQ_QUERY, 8'($urandom), 8'($urandom));
               default: send_plain(REQ_UNUSED, 8'($urandom), 8'($urandom));
            endcase
            sent++;
         end
      end
      req_valid <= 1'b0;
      quiet = 1'b1;

      while (expected_answers.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
